[hdl/hxb_pkg.sv]
// Package for the hex text to bytes unit.
// Holds the character classes, the queue token, result codes and the queue size.
// No dependencies.
package hxb_pkg;

    // Character classes handed from the front end to the back end
    localparam logic [2:0] CLS_DIGIT = 3'd0;
    localparam logic [2:0] CLS_ZERO  = 3'd1;
    localparam logic [2:0] CLS_X     = 3'd2;
    localparam logic [2:0] CLS_SEP   = 3'd3;
    localparam logic [2:0] CLS_TERM  = 3'd4;
    localparam logic [2:0] CLS_BAD   = 3'd5;

    // Status codes of the final result
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_BAD    = 3'd1;
    localparam logic [2:0] ST_SPLIT  = 3'd2;
    localparam logic [2:0] ST_ODD    = 3'd3;
    localparam logic [2:0] ST_OVER   = 3'd4;
    localparam logic [2:0] ST_EMPTY  = 3'd5;

    // Result kinds
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic [2:0] cls;
        logic [3:0] digit;
    } tok_t;

endpackage

[hdl/hxb_intf.sv]
// Handshake interfaces of the hex text to bytes unit.
// Character input, result output and capacity register write channels.
// No dependencies.
interface hxb_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface hxb_res_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;
    logic [2:0] status;
    logic [7:0] byte_count;

    modport source (output valid, output kind, output data_byte, output status,
                    output byte_count, input ready);
    modport sink   (input valid, input kind, input data_byte, input status,
                    input byte_count, output ready);
endinterface

interface hxb_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] max_bytes;

    modport source (output valid, output max_bytes, input ready);
    modport sink   (input valid, input max_bytes, output ready);
endinterface

[hdl/hxb_front.sv]
// Front end: accepts characters and registers their class and digit value.
// Depends on hxb_pkg and hxb_char_if.
module hxb_front
    import hxb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    hxb_char_if.sink      chars,
    output logic          tok_valid,
    output tok_t          tok,
    input  logic          tok_ready
);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [3:0] LETTER_OFS = 4'd9;

    logic tok_valid_reg;
    logic tok_valid_next;
    tok_t tok_reg;
    tok_t tok_next;
    logic take;

    // Accept when the stage is empty or drains this cycle
    assign chars.ready = !tok_valid_reg || tok_ready;
    assign take        = chars.valid && chars.ready;

    // Classify the incoming character
    always_comb
    begin
        tok_next.cls   = CLS_BAD;
        tok_next.digit = '0;
        if (chars.ch == CH_NUL)
        begin
            tok_next.cls = CLS_TERM;
        end
        else if (chars.ch == CH_SPACE || chars.ch == CH_COMMA || chars.ch == CH_COLON ||
                 chars.ch == CH_DASH || chars.ch == CH_UNDER)
        begin
            tok_next.cls = CLS_SEP;
        end
        else if (chars.ch == CH_0)
        begin
            tok_next.cls = CLS_ZERO;
        end
        else if (chars.ch > CH_0 && chars.ch <= CH_9)
        begin
            tok_next.cls   = CLS_DIGIT;
            tok_next.digit = chars.ch[3:0];
        end
        else if ((chars.ch >= CH_LA && chars.ch <= CH_LF) ||
                 (chars.ch >= CH_UA && chars.ch <= CH_UF))
        begin
            tok_next.cls   = CLS_DIGIT;
            tok_next.digit = chars.ch[3:0] + LETTER_OFS;
        end
        else if (chars.ch == CH_LX || chars.ch == CH_UX)
        begin
            tok_next.cls = CLS_X;
        end
    end

    // Hold the stage valid until the queue takes it
    always_comb
    begin
        tok_valid_next = tok_valid_reg;
        if (take)
        begin
            tok_valid_next = 1'b1;
        end
        else if (tok_ready)
        begin
            tok_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_valid = tok_valid_reg;
    assign tok       = tok_reg;

endmodule

[hdl/hxb_queue.sv]
// Short token queue between the front end and the back end.
// Depends on hxb_pkg.
module hxb_queue
    import hxb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  tok_t push_tok,
    output logic push_ready,
    output logic pop_valid,
    output tok_t pop_tok,
    input  logic pop_ready
);

    tok_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_tok    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed tokens
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

[hdl/hxb_back.sv]
// Back end: pairs nibbles into bytes, tracks errors and count, drives results.
// Holds the capacity register. Depends on hxb_pkg, hxb_res_if and hxb_cfg_if.
module hxb_back
    import hxb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     tok_valid,
    input  tok_t     tok,
    output logic     tok_ready,
    hxb_res_if.source results,
    hxb_cfg_if.sink   cfg
);

    localparam logic [7:0] MAX_BYTES_RESET = 8'd255;

    logic [7:0] max_bytes_reg;
    logic       nibble_held_reg;
    logic       nibble_held_next;
    logic [3:0] high_nibble_reg;
    logic [3:0] high_nibble_next;
    logic       zero_held_reg;
    logic       zero_held_next;
    logic [7:0] bytes_done_reg;
    logic [7:0] bytes_done_next;
    logic [2:0] error_code_reg;
    logic [2:0] error_code_next;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic       kind_reg;
    logic       kind_next;
    logic [7:0] data_byte_reg;
    logic [7:0] data_byte_next;
    logic [2:0] status_reg;
    logic [2:0] status_next;
    logic [7:0] byte_count_reg;
    logic [7:0] byte_count_next;

    logic       take;
    logic       emit;
    logic       nh;
    logic [3:0] hn;

    assign cfg.ready = 1'b1;
    assign tok_ready = !out_valid_reg || results.ready;
    assign take      = tok_valid && tok_ready;

    // Process one token
    always_comb
    begin
        nibble_held_next = nibble_held_reg;
        high_nibble_next = high_nibble_reg;
        zero_held_next   = zero_held_reg;
        bytes_done_next  = bytes_done_reg;
        error_code_next  = error_code_reg;
        emit             = 1'b0;
        kind_next        = KIND_BYTE;
        data_byte_next   = '0;
        status_next      = ST_OK;
        byte_count_next  = bytes_done_reg;
        nh               = nibble_held_reg || zero_held_reg;
        hn               = zero_held_reg ? 4'd0 : high_nibble_reg;

        if (tok.cls == CLS_TERM)
        begin
            emit      = 1'b1;
            kind_next = KIND_STATUS;
            if (error_code_reg != ST_OK)
            begin
                status_next = error_code_reg;
            end
            else if (nibble_held_reg || zero_held_reg)
            begin
                status_next = ST_ODD;
            end
            else if (bytes_done_reg == '0)
            begin
                status_next = ST_EMPTY;
            end
            nibble_held_next = 1'b0;
            high_nibble_next = '0;
            zero_held_next   = 1'b0;
            bytes_done_next  = '0;
            error_code_next  = ST_OK;
        end
        else if (error_code_reg == ST_OK)
        begin
            zero_held_next = 1'b0;
            if (zero_held_reg && tok.cls == CLS_X)
            begin
                // Drop the prefix
                nibble_held_next = nibble_held_reg;
            end
            else
            begin
                nibble_held_next = nh;
                high_nibble_next = hn;
                unique case (tok.cls) inside
                    CLS_SEP:
                    begin
                        if (nh)
                        begin
                            error_code_next = ST_SPLIT;
                        end
                    end
                    CLS_ZERO, CLS_DIGIT:
                    begin
                        if (!nh && tok.cls == CLS_ZERO)
                        begin
                            zero_held_next = 1'b1;
                        end
                        else if (!nh)
                        begin
                            nibble_held_next = 1'b1;
                            high_nibble_next = tok.digit;
                        end
                        else if (bytes_done_reg >= max_bytes_reg)
                        begin
                            error_code_next = ST_OVER;
                        end
                        else
                        begin
                            emit             = 1'b1;
                            data_byte_next   = {hn, tok.digit};
                            bytes_done_next  = bytes_done_reg + 1'b1;
                            byte_count_next  = bytes_done_reg + 1'b1;
                            nibble_held_next = 1'b0;
                            high_nibble_next = '0;
                        end
                    end
                    default:
                    begin
                        error_code_next = ST_BAD;
                    end
                endcase
            end
        end
    end

    // Output register: load on a result, drop once transferred
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg   <= MAX_BYTES_RESET;
            nibble_held_reg <= 1'b0;
            high_nibble_reg <= '0;
            zero_held_reg   <= 1'b0;
            bytes_done_reg  <= '0;
            error_code_reg  <= ST_OK;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                max_bytes_reg <= cfg.max_bytes;
            end
            if (take)
            begin
                nibble_held_reg <= nibble_held_next;
                high_nibble_reg <= high_nibble_next;
                zero_held_reg   <= zero_held_next;
                bytes_done_reg  <= bytes_done_next;
                error_code_reg  <= error_code_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            kind_reg       <= kind_next;
            data_byte_reg  <= data_byte_next;
            status_reg     <= status_next;
            byte_count_reg <= byte_count_next;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.kind       = kind_reg;
    assign results.data_byte  = data_byte_reg;
    assign results.status     = status_reg;
    assign results.byte_count = byte_count_reg;

endmodule

[hdl/hex_text_to_bytes_unit.sv]
// Top level of the hex text to bytes unit.
// Depends on hxb_pkg, the hxb interfaces, hxb_front, hxb_queue and hxb_back.
//
//   channel   dir  payload                              transfer when
//   chars     in   ch[7:0]                              valid && ready
//   results   out  kind, data_byte, status, byte_count  valid && ready
//   cfg       in   max_bytes[7:0]                       valid && ready (ready tied high)
//
// One character per cycle while results.ready holds; a character's token passes the
// front register and the queue before its result is loaded into the output register.
// The back end's nibble and count update is the one loop.
// Reset clears all string state and sets max_bytes to 255; no clearing pass.
// A stalled result fills the two-entry queue and the front register, then chars.ready drops.
module hex_text_to_bytes_unit
    import hxb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    hxb_char_if.sink  chars,
    hxb_res_if.source results,
    hxb_cfg_if.sink   cfg
);

    logic f_valid;
    tok_t f_tok;
    logic f_ready;
    logic b_valid;
    tok_t b_tok;
    logic b_ready;

    hxb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars),
        .tok_valid (f_valid),
        .tok       (f_tok),
        .tok_ready (f_ready)
    );

    hxb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_tok   (f_tok),
        .push_ready (f_ready),
        .pop_valid  (b_valid),
        .pop_tok    (b_tok),
        .pop_ready  (b_ready)
    );

    hxb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (b_valid),
        .tok       (b_tok),
        .tok_ready (b_ready),
        .results   (results),
        .cfg       (cfg)
    );

endmodule

[hdl/hxb_checker.sv]
// Port-level checker for the hex text to bytes unit, bound to the top level.
// Depends on hxb_pkg.
module hxb_checker
    import hxb_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       kind,
    input logic [7:0] data_byte,
    input logic [2:0] status,
    input logic [7:0] byte_count
);

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({kind, data_byte, status, byte_count}))
        else $error("result payload changed while stalled");

    // A data byte carries status ok and a nonzero count
    a_byte_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_BYTE |-> status == ST_OK && byte_count != '0)
        else $error("bad data byte fields");

    // A final status is a known code with no data, and empty only at zero count
    a_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_STATUS |->
            data_byte == '0 && status <= ST_EMPTY &&
            (status != ST_EMPTY || byte_count == '0))
        else $error("bad status fields");

endmodule

bind hex_text_to_bytes_unit hxb_checker u_hxb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .kind       (results.kind),
    .data_byte  (results.data_byte),
    .status     (results.status),
    .byte_count (results.byte_count)
);
